// ===== rtl/stt_pkg.sv =====
// shared types, codes and constants of the scene text tokenizer
package stt_pkg;

  // defaults for the top-level parameters
  localparam int POS_BITS_DEF      = 16;
  localparam int MAX_TOKEN_LEN_DEF = 255;

  // depth of the queue between scanner and result sequencer (power of two)
  localparam int QUEUE_DEPTH = 4;

  // token kinds
  localparam logic [3:0] KIND_IDENT     = 4'd0;
  localparam logic [3:0] KIND_NEW       = 4'd1;
  localparam logic [3:0] KIND_NUMBER    = 4'd2;
  localparam logic [3:0] KIND_COMMA     = 4'd3;
  localparam logic [3:0] KIND_DOT       = 4'd4;
  localparam logic [3:0] KIND_EQUAL     = 4'd5;
  localparam logic [3:0] KIND_LPAREN    = 4'd6;
  localparam logic [3:0] KIND_RPAREN    = 4'd7;
  localparam logic [3:0] KIND_SEMICOLON = 4'd8;
  localparam logic [3:0] KIND_ERROR     = 4'd9;

  // error codes
  localparam logic [2:0] ERR_NONE         = 3'd0;
  localparam logic [2:0] ERR_UNRECOGNISED = 3'd1;
  localparam logic [2:0] ERR_LEAD_ZERO    = 3'd2;
  localparam logic [2:0] ERR_END_AFTER_DOT = 3'd3;
  localparam logic [2:0] ERR_EXPECT_DIGIT = 3'd4;

  // characters
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_E      = 8'h65;
  localparam logic [7:0] CH_W      = 8'h77;

  // keyword match progress
  localparam logic [1:0] KW_NONE = 2'd0;
  localparam logic [1:0] KW_N    = 2'd1;
  localparam logic [1:0] KW_NE   = 2'd2;
  localparam logic [1:0] KW_NEW  = 2'd3;

  // scanner mode
  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_IDENT = 3'd1,
    MODE_ZERO  = 3'd2,
    MODE_INT   = 3'd3,
    MODE_DOT   = 3'd4,
    MODE_FRAC  = 3'd5
  } mode_t;

  // one result without its last flag
  typedef struct packed {
    logic [3:0] kind;
    logic [2:0] err;
    logic [15:0] start;
    logic [7:0] len;
    logic [7:0] ch;
  } result_t;

  // all results of one input character
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } bundle_t;

endpackage

// ===== rtl/stt_if.sv =====
// request channels of the scene text tokenizer
interface stt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       end_of_input;

  modport source (output valid, output in_char, output end_of_input, input ready);
  modport sink (input valid, input in_char, input end_of_input, output ready);
endinterface

interface stt_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [2:0]  error_code;
  logic [15:0] token_start;
  logic [7:0]  token_length;
  logic [7:0]  offending_char;
  logic        last_result;

  modport source (output valid, output token_kind, output error_code, output token_start,
                  output token_length, output offending_char, output last_result,
                  input ready);
  modport sink (input valid, input token_kind, input error_code, input token_start,
                input token_length, input offending_char, input last_result,
                output ready);
endinterface

// ===== rtl/stt_front.sv =====
// scanner: takes characters, keeps the token state and builds result bundles
module stt_front #(
  parameter int POS_BITS      = stt_pkg::POS_BITS_DEF,
  parameter int MAX_TOKEN_LEN = stt_pkg::MAX_TOKEN_LEN_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  stt_in_if.sink          in_chan,
  input  logic            q_ready,
  output logic            push_valid,
  output stt_pkg::bundle_t push_bundle
);
  import stt_pkg::*;

  localparam int LEN_BITS = $clog2(MAX_TOKEN_LEN + 1);
  localparam logic [LEN_BITS-1:0] LEN_MAX = LEN_BITS'(MAX_TOKEN_LEN);

  mode_t               mode_r, mode_nxt;
  logic [POS_BITS-1:0] pos_r, pos_nxt;
  logic [POS_BITS-1:0] start_r, start_nxt;
  logic [LEN_BITS-1:0] len_r, len_nxt;
  logic [1:0]          kp_r, kp_nxt;

  logic [7:0]  c;
  logic        accept;
  logic        is_letter, is_digit, is_under;
  logic [LEN_BITS-1:0] len_grown;
  logic [31:0] start_ext, pos_ext, len_ext;
  logic [3:0]  pend_kind;
  logic        a_valid, b_valid, redo;
  result_t     a_res, b_res;

  function automatic result_t mk_res(input logic [3:0] kind, input logic [2:0] err,
                                     input logic [15:0] start, input logic [7:0] len,
                                     input logic [7:0] ch);
    result_t r;
    r.kind  = kind;
    r.err   = err;
    r.start = start;
    r.len   = len;
    r.ch    = ch;
    return r;
  endfunction

  // character classes and widened views of the state
  assign c         = in_chan.in_char;
  assign accept    = in_chan.valid && q_ready;
  assign is_letter = (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z);
  assign is_digit  = (c >= CH_ZERO && c <= CH_NINE);
  assign is_under  = (c == CH_UNDER);
  assign len_grown = (len_r < LEN_MAX) ? len_r + LEN_BITS'(1) : len_r;
  assign start_ext = 32'(start_r);
  assign pos_ext   = 32'(pos_r);
  assign len_ext   = 32'(len_r);
  assign pend_kind = (mode_r == MODE_IDENT) ? ((kp_r == KW_NEW) ? KIND_NEW : KIND_IDENT)
                                            : KIND_NUMBER;

  // mode transitions, pending token flush and start of the next token
  always_comb begin
    mode_nxt  = mode_r;
    pos_nxt   = pos_r;
    start_nxt = start_r;
    len_nxt   = len_r;
    kp_nxt    = kp_r;
    a_valid   = 1'b0;
    b_valid   = 1'b0;
    redo      = 1'b0;
    a_res     = mk_res(pend_kind, ERR_NONE, start_ext[15:0], len_ext[7:0], 8'd0);
    b_res     = mk_res(KIND_ERROR, ERR_UNRECOGNISED, pos_ext[15:0], 8'd0, c);
    if (in_chan.end_of_input) begin
      case (mode_r)
        MODE_IDENT, MODE_ZERO, MODE_INT, MODE_FRAC: begin
          a_valid = 1'b1;
        end
        MODE_DOT: begin
          a_valid = 1'b1;
          a_res   = mk_res(KIND_ERROR, ERR_END_AFTER_DOT, start_ext[15:0], len_ext[7:0], 8'd0);
        end
        default: ;
      endcase
      mode_nxt = MODE_IDLE;
      pos_nxt  = '0;
      len_nxt  = '0;
      kp_nxt   = KW_NONE;
    end else begin
      case (mode_r)
        MODE_IDENT: begin
          if (is_letter || is_digit || is_under) begin
            len_nxt = len_grown;
            if (kp_r == KW_N && c == CH_E) begin
              kp_nxt = KW_NE;
            end else if (kp_r == KW_NE && c == CH_W) begin
              kp_nxt = KW_NEW;
            end else begin
              kp_nxt = KW_NONE;
            end
          end else begin
            a_valid = 1'b1;
            redo    = 1'b1;
          end
        end
        MODE_ZERO: begin
          if (is_digit) begin
            a_valid  = 1'b1;
            a_res    = mk_res(KIND_ERROR, ERR_LEAD_ZERO, start_ext[15:0], len_ext[7:0], c);
            mode_nxt = MODE_IDLE;
          end else if (c == CH_DOT) begin
            len_nxt  = len_grown;
            mode_nxt = MODE_DOT;
          end else begin
            a_valid = 1'b1;
            redo    = 1'b1;
          end
        end
        MODE_INT: begin
          if (is_digit) begin
            len_nxt = len_grown;
          end else if (c == CH_DOT) begin
            len_nxt  = len_grown;
            mode_nxt = MODE_DOT;
          end else begin
            a_valid = 1'b1;
            redo    = 1'b1;
          end
        end
        MODE_DOT: begin
          if (is_digit) begin
            len_nxt  = len_grown;
            mode_nxt = MODE_FRAC;
          end else begin
            a_valid  = 1'b1;
            a_res    = mk_res(KIND_ERROR, ERR_EXPECT_DIGIT, start_ext[15:0], len_ext[7:0], c);
            mode_nxt = MODE_IDLE;
          end
        end
        MODE_FRAC: begin
          if (is_digit) begin
            len_nxt = len_grown;
          end else begin
            a_valid = 1'b1;
            redo    = 1'b1;
          end
        end
        default: begin
          redo = 1'b1;
        end
      endcase

      // the character opens a new token
      if (redo) begin
        start_nxt = pos_r;
        len_nxt   = LEN_BITS'(1);
        kp_nxt    = KW_NONE;
        if (is_letter) begin
          mode_nxt = MODE_IDENT;
          kp_nxt   = (c == CH_N) ? KW_N : KW_NONE;
        end else if (is_digit) begin
          mode_nxt = (c == CH_ZERO) ? MODE_ZERO : MODE_INT;
        end else begin
          mode_nxt = MODE_IDLE;
          b_valid  = 1'b1;
          case (c)
            CH_COMMA:  b_res = mk_res(KIND_COMMA, ERR_NONE, pos_ext[15:0], 8'd1, c);
            CH_DOT:    b_res = mk_res(KIND_DOT, ERR_NONE, pos_ext[15:0], 8'd1, c);
            CH_EQUAL:  b_res = mk_res(KIND_EQUAL, ERR_NONE, pos_ext[15:0], 8'd1, c);
            CH_LPAREN: b_res = mk_res(KIND_LPAREN, ERR_NONE, pos_ext[15:0], 8'd1, c);
            CH_RPAREN: b_res = mk_res(KIND_RPAREN, ERR_NONE, pos_ext[15:0], 8'd1, c);
            CH_SEMI:   b_res = mk_res(KIND_SEMICOLON, ERR_NONE, pos_ext[15:0], 8'd1, c);
            default: begin
              len_nxt = '0;
            end
          endcase
        end
      end
      pos_nxt = pos_r + POS_BITS'(1);
    end
  end

  // bundle towards the queue
  assign in_chan.ready   = q_ready;
  assign push_valid      = accept && (a_valid || b_valid);
  assign push_bundle.two = a_valid && b_valid;
  assign push_bundle.r0  = a_valid ? a_res : b_res;
  assign push_bundle.r1  = b_res;

  // scanner state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      pos_r   <= '0;
      start_r <= '0;
      len_r   <= '0;
      kp_r    <= KW_NONE;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
      len_r   <= len_nxt;
      kp_r    <= kp_nxt;
    end
  end

endmodule

// ===== rtl/stt_queue.sv =====
// short queue of result bundles between scanner and result sequencer
module stt_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  input  stt_pkg::bundle_t push_bundle,
  output logic             push_ready,
  input  logic             pop,
  output logic             pop_valid,
  output stt_pkg::bundle_t pop_bundle
);
  import stt_pkg::*;

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  bundle_t             store_r [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0] count_r, count_nxt;
  logic                do_push, do_pop;

  assign push_ready = (count_r != CNT_BITS'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_bundle = store_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // pointer and fill level update
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + PTR_BITS'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + PTR_BITS'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_BITS'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= push_bundle;
    end
  end

endmodule

// ===== rtl/stt_back.sv =====
// result sequencer: sends the one or two results of each bundle in order
module stt_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  stt_pkg::bundle_t q_bundle,
  output logic             pop,
  stt_out_if.source        out_chan
);
  import stt_pkg::*;

  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r, out_res_nxt;
  logic    out_last_r, out_last_nxt;
  logic    phase_r, phase_nxt;
  logic    load;

  assign load = !out_valid_r || out_chan.ready;

  // pick the next result of the head bundle
  always_comb begin
    pop           = 1'b0;
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    out_last_nxt  = out_last_r;
    if (load) begin
      out_valid_nxt = q_valid;
      if (q_valid) begin
        out_res_nxt = phase_r ? q_bundle.r1 : q_bundle.r0;
        if (!phase_r && q_bundle.two) begin
          out_last_nxt = 1'b0;
          phase_nxt    = 1'b1;
        end else begin
          out_last_nxt = 1'b1;
          phase_nxt    = 1'b0;
          pop          = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.token_kind     = out_res_r.kind;
  assign out_chan.error_code     = out_res_r.err;
  assign out_chan.token_start    = out_res_r.start;
  assign out_chan.token_length   = out_res_r.len;
  assign out_chan.offending_char = out_res_r.ch;
  assign out_chan.last_result    = out_last_r;

endmodule

// ===== rtl/scene_text_tokenizer_unit.sv =====
// Streaming tokenizer: one character request per cycle in, one token result per cycle out while
// the receiver is ready. A character request is taken every cycle while the four-bundle result
// queue has room; the scanner classifies it in the cycle it arrives and pushes its zero, one or
// two results as one bundle. The result sequencer presents one result per cycle from a registered
// output stage; a character's first result passes a queue entry and then the output register, and
// a character that both ends a token and forms a punctuator or an error yields two results, so
// throughput is one character per cycle while the receiver is ready, limited by the single result
// port when two-result characters are frequent. Positions wrap at POS_BITS bits, lengths saturate
// at MAX_TOKEN_LEN; an end-of-text request flushes the pending token and restarts positions at 0.
module scene_text_tokenizer_unit #(
  parameter int POS_BITS      = stt_pkg::POS_BITS_DEF,
  parameter int MAX_TOKEN_LEN = stt_pkg::MAX_TOKEN_LEN_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  stt_in_if.sink    in_chan,
  stt_out_if.source out_chan
);
  import stt_pkg::*;

  logic    q_ready;
  logic    push_valid;
  bundle_t push_bundle;
  logic    pop;
  logic    pop_valid;
  bundle_t pop_bundle;

  // scanner
  stt_front #(
    .POS_BITS      (POS_BITS),
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .q_ready     (q_ready),
    .push_valid  (push_valid),
    .push_bundle (push_bundle)
  );

  // decoupling queue
  stt_queue u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_valid  (push_valid),
    .push_bundle (push_bundle),
    .push_ready  (q_ready),
    .pop         (pop),
    .pop_valid   (pop_valid),
    .pop_bundle  (pop_bundle)
  );

  // result sequencer
  stt_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (pop_valid),
    .q_bundle (pop_bundle),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule

// ===== rtl/stt_checker.sv =====
// port-level checks of the scene text tokenizer and their binding
module stt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  token_kind,
  input logic [2:0]  error_code,
  input logic [15:0] token_start,
  input logic [7:0]  token_length,
  input logic [7:0]  offending_char,
  input logic        last_result
);
  import stt_pkg::*;

  // a stalled result stays offered
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn under stall");

  // a stalled result keeps its contents
  a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(token_kind) && $stable(error_code) &&
      $stable(token_start) && $stable(token_length) && $stable(offending_char) &&
      $stable(last_result))
    else $error("result changed under stall");

  // error code set exactly on error results
  a_err_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((token_kind == KIND_ERROR) == (error_code != ERR_NONE)))
    else $error("error code does not match token kind");

  // punctuators are one character long and carry their character
  a_punct: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && token_kind >= KIND_COMMA && token_kind <= KIND_SEMICOLON |->
      token_length == 8'd1 && offending_char != 8'd0)
    else $error("malformed punctuator result");

endmodule

bind scene_text_tokenizer_unit stt_checker u_stt_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .token_kind     (out_chan.token_kind),
  .error_code     (out_chan.error_code),
  .token_start    (out_chan.token_start),
  .token_length   (out_chan.token_length),
  .offending_char (out_chan.offending_char),
  .last_result    (out_chan.last_result)
);

// ===== tb/sv/scene_text_tokenizer_unit_test.sv =====
// self-checking bench for the scene text tokenizer: directed and random character streams
module scene_text_tokenizer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import stt_pkg::*;

  localparam int POS_W       = POS_BITS_DEF;
  localparam int TOK_LEN_MAX = MAX_TOKEN_LEN_DEF;
  localparam int HOLD_CYCLES = 200;
  localparam int RANDOM_CHARS = 1000;
  // characters of one text sent with no idling on either side
  localparam int STEADY_CHARS = 300;

  // one character request as queued for the driver
  typedef struct {
    logic [7:0] ch;
    logic       eoi;
  } char_req_t;

  // one expected token result
  typedef struct {
    logic [3:0]  kind;
    logic [2:0]  err;
    logic [15:0] start;
    logic [7:0]  len;
    logic [7:0]  ch;
    logic        last;
  } token_rec_t;

  logic clk;
  logic rst_n;

  stt_in_if  in_chan ();
  stt_out_if out_chan ();

  scene_text_tokenizer_unit #(
    .POS_BITS      (POS_W),
    .MAX_TOKEN_LEN (TOK_LEN_MAX)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  char_req_t  char_queue [$];
  token_rec_t expected_tokens [$];
  char_req_t  held;

  // scanner state as the bench tracks it
  mode_t       scan_mode_q;
  logic [15:0] pos_q;
  logic [15:0] tok_start_q;
  logic [7:0]  tok_len_q;
  logic [1:0]  kw_q;

  bit steady;
  bit sink_hold;
  bit start_hold;

  int error_count;
  int chars_sent;
  int texts_ended;
  int results_seen;
  int errors_seen;
  int keywords_seen;
  int saturated_seen;
  int wraps_seen;

  string keyword_words [8] = '{"new", "ne", "n", "news", "nEw", "anew", "new_", "New"};
  logic [7:0] punct_chars [6] = '{CH_COMMA, CH_DOT, CH_EQUAL, CH_LPAREN, CH_RPAREN, CH_SEMI};

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= 100) $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z);
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic token_rec_t make_rec(input logic [3:0] kind, input logic [2:0] err,
                                          input logic [15:0] start, input logic [7:0] len,
                                          input logic [7:0] ch);
    token_rec_t r;
    r.kind  = kind;
    r.err   = err;
    r.start = start;
    r.len   = len;
    r.ch    = ch;
    r.last  = 1'b0;
    return r;
  endfunction

  function automatic token_rec_t pending_token();
    logic [3:0] kind;
    if (scan_mode_q == MODE_IDENT) kind = (kw_q == KW_NEW) ? KIND_NEW : KIND_IDENT;
    else kind = KIND_NUMBER;
    return make_rec(kind, ERR_NONE, tok_start_q, tok_len_q, 8'd0);
  endfunction

  task automatic lengthen();
    if (int'(tok_len_q) < TOK_LEN_MAX) tok_len_q++;
  endtask

  // advance the tracked scanner by one accepted request and queue its results
  task automatic scan_char(input logic [7:0] c, input logic eoi);
    token_rec_t found [$];
    logic [15:0] p;
    bit restart;
    logic [3:0] pk;
    p = pos_q;
    restart = 1'b0;
    if (eoi) begin
      case (scan_mode_q)
        MODE_IDENT, MODE_ZERO, MODE_INT, MODE_FRAC: found.push_back(pending_token());
        MODE_DOT: found.push_back(make_rec(KIND_ERROR, ERR_END_AFTER_DOT, tok_start_q,
                                           tok_len_q, 8'd0));
        default: ;
      endcase
      scan_mode_q = MODE_IDLE;
      pos_q       = '0;
      tok_len_q   = '0;
      kw_q        = KW_NONE;
      texts_ended++;
    end else begin
      case (scan_mode_q)
        MODE_IDENT: begin
          if (is_letter(c) || is_digit(c) || c == CH_UNDER) begin
            lengthen();
            if (kw_q == KW_N && c == CH_E) kw_q = KW_NE;
            else if (kw_q == KW_NE && c == CH_W) kw_q = KW_NEW;
            else kw_q = KW_NONE;
          end else begin
            found.push_back(pending_token());
            restart = 1'b1;
          end
        end
        MODE_ZERO: begin
          if (is_digit(c)) begin
            found.push_back(make_rec(KIND_ERROR, ERR_LEAD_ZERO, tok_start_q, tok_len_q, c));
            scan_mode_q = MODE_IDLE;
          end else if (c == CH_DOT) begin
            lengthen();
            scan_mode_q = MODE_DOT;
          end else begin
            found.push_back(pending_token());
            restart = 1'b1;
          end
        end
        MODE_INT: begin
          if (is_digit(c)) begin
            lengthen();
          end else if (c == CH_DOT) begin
            lengthen();
            scan_mode_q = MODE_DOT;
          end else begin
            found.push_back(pending_token());
            restart = 1'b1;
          end
        end
        MODE_DOT: begin
          if (is_digit(c)) begin
            lengthen();
            scan_mode_q = MODE_FRAC;
          end else begin
            found.push_back(make_rec(KIND_ERROR, ERR_EXPECT_DIGIT, tok_start_q, tok_len_q, c));
            scan_mode_q = MODE_IDLE;
          end
        end
        MODE_FRAC: begin
          if (is_digit(c)) begin
            lengthen();
          end else begin
            found.push_back(pending_token());
            restart = 1'b1;
          end
        end
        default: restart = 1'b1;
      endcase
      // the terminating character opens the next token
      if (restart) begin
        tok_start_q = p;
        tok_len_q   = 8'd1;
        kw_q        = KW_NONE;
        if (is_letter(c)) begin
          scan_mode_q = MODE_IDENT;
          kw_q = (c == CH_N) ? KW_N : KW_NONE;
        end else if (is_digit(c)) begin
          scan_mode_q = (c == CH_ZERO) ? MODE_ZERO : MODE_INT;
        end else begin
          scan_mode_q = MODE_IDLE;
          case (c)
            CH_COMMA:  pk = KIND_COMMA;
            CH_DOT:    pk = KIND_DOT;
            CH_EQUAL:  pk = KIND_EQUAL;
            CH_LPAREN: pk = KIND_LPAREN;
            CH_RPAREN: pk = KIND_RPAREN;
            CH_SEMI:   pk = KIND_SEMICOLON;
            default:   pk = KIND_ERROR;
          endcase
          if (pk == KIND_ERROR) begin
            tok_len_q = '0;
            found.push_back(make_rec(KIND_ERROR, ERR_UNRECOGNISED, p, 8'd0, c));
          end else begin
            found.push_back(make_rec(pk, ERR_NONE, p, 8'd1, c));
          end
        end
      end
      if (p == 16'hFFFF) wraps_seen++;
      pos_q = p + 16'd1;
    end
    if (found.size() > 0) found[found.size() - 1].last = 1'b1;
    foreach (found[i]) expected_tokens.push_back(found[i]);
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid        <= 1'b0;
      in_chan.in_char      <= 8'd0;
      in_chan.end_of_input <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        scan_char(held.ch, held.eoi);
        chars_sent++;
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (char_queue.size() > 0 && (steady || $urandom_range(99) >= 29)) begin
          held = char_queue.pop_front();
          in_chan.valid        <= 1'b1;
          in_chan.in_char      <= held.ch;
          in_chan.end_of_input <= held.eoi;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // compare one accepted result with the oldest expected token
  task automatic check_result();
    token_rec_t want;
    if (expected_tokens.size() == 0) begin
      flag_error($sformatf("result kind %0d start %0d with nothing expected",
                           out_chan.token_kind, out_chan.token_start));
    end else begin
      want = expected_tokens.pop_front();
      results_seen++;
      if (want.kind == KIND_ERROR) errors_seen++;
      if (want.kind == KIND_NEW) keywords_seen++;
      if (int'(want.len) == TOK_LEN_MAX) saturated_seen++;
      if (out_chan.token_kind != want.kind)
        flag_error($sformatf("token_kind got %0d expected %0d (start %0d)",
                             out_chan.token_kind, want.kind, want.start));
      if (out_chan.error_code != want.err)
        flag_error($sformatf("error_code got %0d expected %0d (start %0d)",
                             out_chan.error_code, want.err, want.start));
      if (out_chan.token_start != want.start)
        flag_error($sformatf("token_start got %0d expected %0d",
                             out_chan.token_start, want.start));
      if (out_chan.token_length != want.len)
        flag_error($sformatf("token_length got %0d expected %0d (start %0d)",
                             out_chan.token_length, want.len, want.start));
      if (out_chan.offending_char != want.ch)
        flag_error($sformatf("offending_char got %0h expected %0h (start %0d)",
                             out_chan.offending_char, want.ch, want.start));
      if (out_chan.last_result != want.last)
        flag_error($sformatf("last_result got %0b expected %0b (start %0d)",
                             out_chan.last_result, want.last, want.start));
    end
  endtask

  // result monitor and receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) check_result();
      out_chan.ready <= !sink_hold && (steady || $urandom_range(99) >= 29);
    end
  end

  // long receiver hold-off while requests keep coming
  initial begin
    sink_hold = 1'b0;
    wait (start_hold);
    @(negedge clk);
    sink_hold = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    sink_hold = 1'b0;
  end

  function automatic logic [7:0] rand_letter();
    return ($urandom_range(1) ? CH_UP_A : CH_LO_A) + 8'($urandom_range(25));
  endfunction

  function automatic logic [7:0] rand_digit();
    return CH_ZERO + 8'($urandom_range(9));
  endfunction

  function automatic logic [7:0] rand_ident_tail();
    int unsigned k;
    k = $urandom_range(9);
    if (k < 6) return rand_letter();
    if (k < 9) return rand_digit();
    return CH_UNDER;
  endfunction

  function automatic logic [7:0] rand_non_digit();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (is_digit(c));
    return c;
  endfunction

  task automatic add_char(input logic [7:0] c);
    char_req_t r;
    r.ch  = c;
    r.eoi = 1'b0;
    char_queue.push_back(r);
  endtask

  task automatic add_end();
    char_req_t r;
    r.ch  = 8'($urandom_range(255));
    r.eoi = 1'b1;
    char_queue.push_back(r);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endtask

  // one token-shaped piece of text: mostly well-formed, some broken, some noise
  task automatic add_fragment(input bit allow_end);
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(99);
    if (pick < 30) begin
      if ($urandom_range(3) == 0) begin
        add_text(keyword_words[$urandom_range(7)]);
      end else begin
        n = ($urandom_range(99) == 0) ? $urandom_range(300, 256) : $urandom_range(8, 1);
        add_char(rand_letter());
        repeat (n - 1) add_char(rand_ident_tail());
      end
    end else if (pick < 55) begin
      n = ($urandom_range(99) == 0) ? $urandom_range(280, 256) : $urandom_range(4, 1);
      if ($urandom_range(3) == 0) begin
        add_char(CH_ZERO);
      end else begin
        add_char(CH_ZERO + 8'($urandom_range(9, 1)));
        repeat (n - 1) add_char(rand_digit());
      end
      if ($urandom_range(2) == 0) begin
        add_char(CH_DOT);
        repeat ($urandom_range(3, 1)) add_char(rand_digit());
      end
    end else if (pick < 75) begin
      add_char(punct_chars[$urandom_range(5)]);
    end else if (pick < 85) begin
      case ($urandom_range(2))
        0: begin
          add_char(CH_ZERO);
          add_char(rand_digit());
        end
        1: begin
          add_char(rand_digit());
          add_char(CH_DOT);
          add_char(rand_non_digit());
        end
        default: begin
          add_char(rand_digit());
          add_char(CH_DOT);
          if (allow_end) add_end();
        end
      endcase
    end else begin
      add_char(8'($urandom_range(255)));
    end
    if (allow_end && $urandom_range(19) == 0) add_end();
  endtask

  // wait until every request is taken and every expected token has come back
  task automatic wait_drained();
    do @(negedge clk);
    while (char_queue.size() != 0 || in_chan.valid || expected_tokens.size() != 0);
  endtask

  // stimulus and end of run
  initial begin
    rst_n                = 1'b0;
    in_chan.valid        = 1'b0;
    in_chan.in_char      = 8'd0;
    in_chan.end_of_input = 1'b0;
    out_chan.ready       = 1'b0;
    steady               = 1'b0;
    start_hold           = 1'b0;
    scan_mode_q          = MODE_IDLE;
    pos_q                = '0;
    tok_start_q          = '0;
    tok_len_q            = '0;
    kw_q                 = KW_NONE;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: keyword, punctuators, field extremes, every error and end of text
    @(negedge clk);
    add_text("new;");
    add_text("Zz_(");
    add_text("07");
    add_text("0.9)");
    add_text("1.x");
    add_text("9.");
    add_end();
    add_end();
    add_char(8'hFF);
    add_char(8'h00);
    add_text(",.=A");
    add_end();
    wait_drained();

    // random text with idling on both sides and one long receiver hold-off
    while (char_queue.size() < RANDOM_CHARS) add_fragment(1'b1);
    start_hold = 1'b1;
    wait_drained();

    // one text with no idling at all
    steady = 1'b1;
    add_end();
    while (char_queue.size() < STEADY_CHARS) add_fragment(1'b0);
    add_end();
    wait_drained();
    steady = 1'b0;

    repeat (10) @(negedge clk);
    if (expected_tokens.size() != 0)
      flag_error($sformatf("%0d expected tokens never arrived", expected_tokens.size()));
    $display("run covered %0d characters in %0d texts, %0d tokens checked", chars_sent,
             texts_ended, results_seen);
    $display("  of them %0d errors, %0d keywords, %0d saturated lengths; %0d position wraps",
             errors_seen, keywords_seen, saturated_seen, wraps_seen);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
